// File: rtl/h3126_pkg.sv
package h3126_pkg;

	localparam int DATA_BITS = 26;
	localparam int CODE_BITS = 31;
	localparam int BYTE_BITS = 8;

	typedef logic [DATA_BITS-1:0] data_word_t;
	typedef logic [CODE_BITS-1:0] codeword_t;
	typedef logic [4:0]           pos_t;

	// codeword positions of data bits, in arrival order
	localparam pos_t DATA_POS [DATA_BITS] = '{
		5'd2,  5'd4,  5'd5,  5'd6,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
		5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
		5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30
	};

	localparam pos_t PAR_POS_0  = 5'd0;
	localparam pos_t PAR_POS_1  = 5'd1;
	localparam pos_t PAR_POS_3  = 5'd3;
	localparam pos_t PAR_POS_7  = 5'd7;
	localparam pos_t PAR_POS_15 = 5'd15;

	localparam codeword_t PAR_MASK_0  = 31'h5555_5555;
	localparam codeword_t PAR_MASK_1  = 31'h6666_6666;
	localparam codeword_t PAR_MASK_3  = 31'h7878_7878;
	localparam codeword_t PAR_MASK_7  = 31'h7F80_7F80;
	localparam codeword_t PAR_MASK_15 = 31'h7FFF_8000;

endpackage

// File: rtl/h3126_enc.sv
module h3126_enc (
	input  h3126_pkg::data_word_t word,
	output h3126_pkg::codeword_t  code
);
	import h3126_pkg::*;

	codeword_t placed;

	always_comb begin
		placed = '0;
		for (int k = 0; k < DATA_BITS; k++) begin
			placed[DATA_POS[k]] = word[DATA_BITS-1-k];
		end
	end

	always_comb begin
		code              = placed;
		code[PAR_POS_0]   = ^(placed & PAR_MASK_0);
		code[PAR_POS_1]   = ^(placed & PAR_MASK_1);
		code[PAR_POS_3]   = ^(placed & PAR_MASK_3);
		code[PAR_POS_7]   = ^(placed & PAR_MASK_7);
		code[PAR_POS_15]  = ^(placed & PAR_MASK_15);
	end

endmodule

// File: rtl/hamming_31_26_byte_stream_encoder.sv
// Hamming (31,26) encoder over a byte stream.
// A codeword is registered into the output register, or into the skid entry while stalled.
// Throughput: one byte per cycle while the skid is empty; gathering and parity are combinational.
// A two-entry output (register plus skid) keeps input flowing for one stalled word.
// Reset (async, active low) empties the gatherer and the output entries.
module hamming_31_26_byte_stream_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	output logic                 data_ready,
	input  logic [7:0]           data_byte,
	output logic                 code_valid,
	input  logic                 code_ready,
	output h3126_pkg::codeword_t codeword
);
	import h3126_pkg::*;

	localparam int HELD_BITS = DATA_BITS - 1;
	localparam int COMB_BITS = HELD_BITS + BYTE_BITS;

	logic [HELD_BITS-1:0] gathered_q;
	logic [4:0]           count_q;
	logic                 skid_valid_q;
	codeword_t            skid_q;
	logic                 code_valid_q;
	codeword_t            code_q;

	logic                 accept;
	logic [5:0]           total;
	logic [5:0]           over;
	logic [2:0]           extra;
	logic                 produce;
	logic [COMB_BITS-1:0] combined;
	logic [COMB_BITS-1:0] shifted;
	logic [BYTE_BITS-1:0] rest_mask;
	data_word_t           word;
	codeword_t            new_code;

	assign data_ready = !skid_valid_q;
	assign accept     = data_valid && data_ready;
	assign code_valid = code_valid_q;
	assign codeword   = code_q;

	always_comb begin
		total     = {1'b0, count_q} + 6'(BYTE_BITS);
		over      = total - 6'(DATA_BITS);
		extra     = over[2:0];
		produce   = accept && (total >= 6'(DATA_BITS));
		combined  = {gathered_q, data_byte};
		shifted   = combined >> extra;
		word      = shifted[DATA_BITS-1:0];
		rest_mask = (BYTE_BITS'(1) << extra) - BYTE_BITS'(1);
	end

	h3126_enc u_enc (
		.word (word),
		.code (new_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gathered_q <= '0;
			count_q    <= '0;
		end else if (accept) begin
			if (total >= 6'(DATA_BITS)) begin
				gathered_q <= {{(HELD_BITS-BYTE_BITS){1'b0}}, combined[BYTE_BITS-1:0] & rest_mask};
				count_q    <= {2'b00, extra};
			end else begin
				gathered_q <= combined[HELD_BITS-1:0];
				count_q    <= total[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!code_valid_q || code_ready) begin
			if (skid_valid_q) begin
				code_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				code_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!code_valid_q || code_ready) begin
			code_q <= skid_valid_q ? skid_q : new_code;
		end else if (produce) begin
			skid_q <= new_code;
		end
	end

endmodule
